// ===== rtl/spm_pkg.sv =====
// ----------------------------------------------------------------------------
// spm_pkg
// Shared types, field widths and codes of the slot allocator with position
// map: operation and status codes and the packing of the stream words.
// ----------------------------------------------------------------------------
package spm_pkg;

  // Default build sizes.
  localparam int MAX_SLOTS_DEFAULT  = 256;
  localparam int COORD_BITS_DEFAULT = 16;

  // Fixed widths of the port fields.
  localparam int CAP_W    = 9;
  localparam int FUNC_W   = 3;
  localparam int POS_W    = 16;
  localparam int SLOT_W   = 8;
  localparam int STATUS_W = 2;
  localparam int LIVE_W   = 9;

  // Capacity after reset.
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 9'd256;

  // Input tdata: pos_x, pos_y, pos_z, slot_index from bit 0 up.
  localparam int IN_X_LSB    = 0;
  localparam int IN_Y_LSB    = IN_X_LSB + POS_W;
  localparam int IN_Z_LSB    = IN_Y_LSB + POS_W;
  localparam int IN_IDX_LSB  = IN_Z_LSB + POS_W;
  localparam int IN_DATA_W   = IN_IDX_LSB + SLOT_W;

  // Output tdata: found, slot_out, pos_x_out, pos_y_out, pos_z_out,
  // slot_dirty, slot_active, any_dirty, live_count from bit 0 up.
  localparam int OUT_FOUND_BIT  = 0;
  localparam int OUT_SLOT_LSB   = OUT_FOUND_BIT + 1;
  localparam int OUT_X_LSB      = OUT_SLOT_LSB + SLOT_W;
  localparam int OUT_Y_LSB      = OUT_X_LSB + POS_W;
  localparam int OUT_Z_LSB      = OUT_Y_LSB + POS_W;
  localparam int OUT_DIRTY_BIT  = OUT_Z_LSB + POS_W;
  localparam int OUT_ACTIVE_BIT = OUT_DIRTY_BIT + 1;
  localparam int OUT_ANY_BIT    = OUT_ACTIVE_BIT + 1;
  localparam int OUT_LIVE_LSB   = OUT_ANY_BIT + 1;
  localparam int OUT_USED_W     = OUT_LIVE_LSB + LIVE_W;
  localparam int OUT_DATA_W     = ((OUT_USED_W + 7) / 8) * 8;

  // Operation carried in the input tuser.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD         = 3'd0,
    FUNC_REMOVE      = 3'd1,
    FUNC_LOOKUP      = 3'd2,
    FUNC_MARK_DIRTY  = 3'd3,
    FUNC_MARK_CLEAN  = 3'd4,
    FUNC_CLEAR_DIRTY = 3'd5,
    FUNC_READ_SLOT   = 3'd6
  } func_t;

  // Result status carried in the output tuser.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_RANGE     = 2'd3
  } status_t;

endpackage

// ===== rtl/spm_ram.sv =====
// ----------------------------------------------------------------------------
// spm_ram
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module spm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/slot_allocator_position_map_unit.sv =====
// ----------------------------------------------------------------------------
// slot_allocator_position_map_unit
// Slot table with a position map, a LIFO free list and dirty marks, driven
// by one operation per input transfer and answering with one result transfer.
// ----------------------------------------------------------------------------
// The unit takes one operation at a time. Add, remove and lookup compare the
// stored positions one slot per cycle through the single read port of the
// position memory, walking only the slots handed out so far, at most
// MAX_SLOTS of them; an add that reuses a freed slot then pops it off the
// free list through the free-list memory read. Mark dirty, mark clean, clear
// all dirty and a rejected operation go straight to the output state; read
// slot of an active slot first reads the position memory. Active and dirty marks
// sit in flip-flops cleared by reset, so no clearing pass is needed and the
// unit is ready right after reset. A finished result waits in the output
// register while the next operation is accepted.
module slot_allocator_position_map_unit #(
  parameter int MAX_SLOTS  = spm_pkg::MAX_SLOTS_DEFAULT,
  parameter int COORD_BITS = spm_pkg::COORD_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration: capacity.
  input  logic                           cfg_wr_en,
  input  logic [spm_pkg::CAP_W-1:0]      cfg_wr_data,
  // Operation stream.
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // pos_x[15:0], pos_y[31:16], pos_z[47:32], slot_index[55:48]
  input  logic [spm_pkg::IN_DATA_W-1:0]  s_tdata,
  // func[2:0]
  input  logic [spm_pkg::FUNC_W-1:0]     s_tuser,
  // Result stream.
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // found[0], slot_out[8:1], pos_x_out[24:9], pos_y_out[40:25],
  // pos_z_out[56:41], slot_dirty[57], slot_active[58], any_dirty[59],
  // live_count[68:60], zero fill above
  output logic [spm_pkg::OUT_DATA_W-1:0] m_tdata,
  // status[1:0]
  output logic [spm_pkg::STATUS_W-1:0]   m_tuser
);

  localparam int IDX_W  = $clog2(MAX_SLOTS);
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int WIDE_W = (CNT_W > spm_pkg::CAP_W) ? CNT_W : spm_pkg::CAP_W;
  localparam int KEY_W  = 3 * COORD_BITS;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_POP  = 5'b00100,
    ST_READ = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t                      state;
  logic [spm_pkg::CAP_W-1:0]   capacity;
  logic [MAX_SLOTS-1:0]        active;
  logic [MAX_SLOTS-1:0]        dirty;
  logic [CNT_W-1:0]            dirty_live;
  logic [CNT_W-1:0]            active_count;
  logic [CNT_W-1:0]            freed_top;
  logic [CNT_W-1:0]            fresh_next;

  spm_pkg::func_t              op;
  logic [KEY_W-1:0]            key;
  logic [CNT_W-1:0]            scan_i;
  logic                        chk_v;
  logic [IDX_W-1:0]            chk_i;

  spm_pkg::status_t            res_status;
  logic                        res_found;
  logic [IDX_W-1:0]            res_slot;
  logic [spm_pkg::POS_W-1:0]   res_x;
  logic [spm_pkg::POS_W-1:0]   res_y;
  logic [spm_pkg::POS_W-1:0]   res_z;
  logic                        res_dirty;
  logic                        res_active;

  spm_pkg::func_t              in_func;
  logic [spm_pkg::SLOT_W-1:0]  in_idx;
  logic [IDX_W-1:0]            in_slot;
  logic [KEY_W-1:0]            in_key;
  logic [CNT_W-1:0]            cap;
  logic                        idx_out_of_range;
  logic                        accept;

  logic [KEY_W-1:0]            pos_rdata;
  logic [IDX_W-1:0]            pos_raddr;
  logic                        alloc_we;
  logic [IDX_W-1:0]            alloc_slot;
  logic [IDX_W-1:0]            stack_rdata;
  logic [CNT_W-1:0]            freed_top_m1;
  logic                        push_we;
  logic                        hit;
  logic                        scan_more;
  logic                        out_free;

  // Effective capacity: the register clipped to the table depth.
  always_comb begin
    if (WIDE_W'(capacity) > WIDE_W'(MAX_SLOTS)) begin
      cap = CNT_W'(MAX_SLOTS);
    end else begin
      cap = CNT_W'(capacity);
    end
  end

  // Unpack the operation; coordinates keep their low COORD_BITS bits.
  assign in_func = spm_pkg::func_t'(s_tuser);
  assign in_idx  = s_tdata[spm_pkg::IN_IDX_LSB +: spm_pkg::SLOT_W];
  assign in_slot = IDX_W'(in_idx);
  assign in_key  = {COORD_BITS'(s_tdata[spm_pkg::IN_Z_LSB +: spm_pkg::POS_W]),
                    COORD_BITS'(s_tdata[spm_pkg::IN_Y_LSB +: spm_pkg::POS_W]),
                    COORD_BITS'(s_tdata[spm_pkg::IN_X_LSB +: spm_pkg::POS_W])};
  assign idx_out_of_range = WIDE_W'(in_idx) >= WIDE_W'(cap);

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Scan compare: the data read last cycle against the requested position.
  assign scan_more = scan_i < fresh_next;
  assign hit       = chk_v && active[chk_i] && (pos_rdata == key);

  // Position memory read address: scan pointer, else the addressed slot.
  assign pos_raddr = (state == ST_SCAN) ? scan_i[IDX_W-1:0] : in_slot;

  // Allocation of a fresh slot on a scan miss, or a slot popped off the list.
  assign alloc_we = (state == ST_POP) ||
                    ((state == ST_SCAN) && !hit && !scan_more && (op == spm_pkg::FUNC_ADD) &&
                     (freed_top == '0) && (fresh_next < cap));
  assign alloc_slot = (state == ST_POP) ? stack_rdata : fresh_next[IDX_W-1:0];

  // Free list: top entry always on the read port, push on a removal.
  assign freed_top_m1 = freed_top - CNT_W'(1);
  assign push_we = (state == ST_SCAN) && hit && (op == spm_pkg::FUNC_REMOVE) &&
                   (freed_top < CNT_W'(MAX_SLOTS));

  spm_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_SLOTS)
  ) u_pos_ram (
    .clk   (clk),
    .we    (alloc_we),
    .waddr (alloc_slot),
    .wdata (key),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  spm_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_SLOTS)
  ) u_free_ram (
    .clk   (clk),
    .we    (push_we),
    .waddr (freed_top[IDX_W-1:0]),
    .wdata (chk_i),
    .raddr (freed_top_m1[IDX_W-1:0]),
    .rdata (stack_rdata)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= spm_pkg::CAPACITY_RESET;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  // Sequencer, table state and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      active       <= '0;
      dirty        <= '0;
      dirty_live   <= '0;
      active_count <= '0;
      freed_top    <= '0;
      fresh_next   <= '0;
      chk_v        <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      // The output register empties when its transfer completes.
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      // A new slot becomes active and dirty.
      if (alloc_we) begin
        active[alloc_slot] <= 1'b1;
        dirty[alloc_slot]  <= 1'b1;
        dirty_live         <= dirty_live + 1'b1;
        active_count       <= active_count + 1'b1;
        res_slot           <= alloc_slot;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            op         <= in_func;
            key        <= in_key;
            scan_i     <= '0;
            chk_v      <= 1'b0;
            res_status <= spm_pkg::STATUS_OK;
            res_found  <= 1'b0;
            res_slot   <= '0;
            res_x      <= '0;
            res_y      <= '0;
            res_z      <= '0;
            res_dirty  <= 1'b0;
            res_active <= 1'b0;
            state      <= ST_OUT;
            unique case (in_func)
              spm_pkg::FUNC_ADD: begin
                if (active_count >= cap) begin
                  res_status <= spm_pkg::STATUS_FULL;
                end else begin
                  state <= ST_SCAN;
                end
              end
              spm_pkg::FUNC_REMOVE, spm_pkg::FUNC_LOOKUP: begin
                state <= ST_SCAN;
              end
              spm_pkg::FUNC_MARK_DIRTY: begin
                if (idx_out_of_range) begin
                  res_status <= spm_pkg::STATUS_RANGE;
                end else begin
                  if (active[in_slot] && !dirty[in_slot]) begin
                    dirty_live <= dirty_live + 1'b1;
                  end
                  dirty[in_slot] <= 1'b1;
                end
              end
              spm_pkg::FUNC_MARK_CLEAN: begin
                if (idx_out_of_range) begin
                  res_status <= spm_pkg::STATUS_RANGE;
                end else begin
                  if (active[in_slot] && dirty[in_slot]) begin
                    dirty_live <= dirty_live - 1'b1;
                  end
                  dirty[in_slot] <= 1'b0;
                end
              end
              spm_pkg::FUNC_CLEAR_DIRTY: begin
                dirty      <= '0;
                dirty_live <= '0;
              end
              spm_pkg::FUNC_READ_SLOT: begin
                if (idx_out_of_range) begin
                  res_status <= spm_pkg::STATUS_RANGE;
                end else if (active[in_slot]) begin
                  res_active <= 1'b1;
                  res_dirty  <= dirty[in_slot];
                  state      <= ST_READ;
                end
              end
              default: begin
                // Unused operation code: no change, status ok.
              end
            endcase
          end
        end

        ST_SCAN: begin
          // Issue the next slot while the previous one is compared.
          if (scan_more) begin
            scan_i <= scan_i + 1'b1;
          end
          chk_v <= scan_more;
          chk_i <= scan_i[IDX_W-1:0];

          if (hit) begin
            res_slot <= chk_i;
            state    <= ST_OUT;
            if (op == spm_pkg::FUNC_REMOVE) begin
              active[chk_i] <= 1'b0;
              dirty[chk_i]  <= 1'b0;
              if (dirty[chk_i]) begin
                dirty_live <= dirty_live - 1'b1;
              end
              if (push_we) begin
                freed_top <= freed_top + 1'b1;
              end
              if (active_count != '0) begin
                active_count <= active_count - 1'b1;
              end
            end else begin
              res_found <= 1'b1;
            end
          end else if (!scan_more) begin
            state <= ST_OUT;
            if (op == spm_pkg::FUNC_ADD) begin
              if (freed_top != '0) begin
                state <= ST_POP;
              end else if (alloc_we) begin
                fresh_next <= fresh_next + 1'b1;
              end else begin
                res_status <= spm_pkg::STATUS_FULL;
              end
            end else begin
              res_status <= spm_pkg::STATUS_NOT_FOUND;
            end
          end
        end

        ST_POP: begin
          // Free-list top is on the read data; the allocation takes it.
          freed_top <= freed_top_m1;
          state     <= ST_OUT;
        end

        ST_READ: begin
          // Stored coordinates come back sign-extended from COORD_BITS.
          res_x <= spm_pkg::POS_W'($signed(pos_rdata[0 +: COORD_BITS]));
          res_y <= spm_pkg::POS_W'($signed(pos_rdata[COORD_BITS +: COORD_BITS]));
          res_z <= spm_pkg::POS_W'($signed(pos_rdata[2*COORD_BITS +: COORD_BITS]));
          state <= ST_OUT;
        end

        ST_OUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output word, loaded when the result moves into the output register.
  always_ff @(posedge clk) begin
    if ((state == ST_OUT) && out_free) begin
      m_tuser <= res_status;
      m_tdata <= '0;
      m_tdata[spm_pkg::OUT_FOUND_BIT]                    <= res_found;
      m_tdata[spm_pkg::OUT_SLOT_LSB +: spm_pkg::SLOT_W]  <= spm_pkg::SLOT_W'(res_slot);
      m_tdata[spm_pkg::OUT_X_LSB +: spm_pkg::POS_W]      <= res_x;
      m_tdata[spm_pkg::OUT_Y_LSB +: spm_pkg::POS_W]      <= res_y;
      m_tdata[spm_pkg::OUT_Z_LSB +: spm_pkg::POS_W]      <= res_z;
      m_tdata[spm_pkg::OUT_DIRTY_BIT]                    <= res_dirty;
      m_tdata[spm_pkg::OUT_ACTIVE_BIT]                   <= res_active;
      m_tdata[spm_pkg::OUT_ANY_BIT]                      <= (dirty_live != '0);
      m_tdata[spm_pkg::OUT_LIVE_LSB +: spm_pkg::LIVE_W]  <= spm_pkg::LIVE_W'(active_count);
    end
  end

endmodule

// ===== rtl/spm_checker.sv =====
// ----------------------------------------------------------------------------
// spm_checker
// Port-level checks of the slot allocator: reset, one operation at a time,
// result holding, and consistency between result fields.
// ----------------------------------------------------------------------------
module spm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [spm_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [spm_pkg::STATUS_W-1:0]   m_tuser
);

  // No result is offered right after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // An accepted operation is followed by input ready low.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready in the cycle after a transfer");

  // A stalled result holds its word.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

  // A found position always comes with status ok.
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[spm_pkg::OUT_FOUND_BIT]) |->
      (m_tuser == spm_pkg::STATUS_OK))
    else $error("found flag with an error status");

  // A dirty active slot implies at least one live slot.
  a_dirty_live: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[spm_pkg::OUT_ANY_BIT]) |->
      (m_tdata[spm_pkg::OUT_LIVE_LSB +: spm_pkg::LIVE_W] != '0))
    else $error("dirty flag with no live slot");

endmodule

bind slot_allocator_position_map_unit spm_checker u_spm_checker (.*);
